FILE: hw/rtl/mqrl_pkg.sv
// mqrl_pkg: request/response payload types, command and status codes, and the
// control bundle between the controller and the datapath of the ready-list core.
// Depends on nothing; mqrl_ctrl, mqrl_datapath and the core use it by scoped names.
package mqrl_pkg;

    localparam int CMD_W     = 2;
    localparam int QID_W     = 4;
    localparam int PAYLOAD_W = 32;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_PUSH     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RING_POP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP      = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [QID_W-1:0]     queue_id;
        logic [PAYLOAD_W-1:0] payload;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [QID_W-1:0]     ready_queue;
        logic [PAYLOAD_W-1:0] message;
        logic [FILL_W-1:0]    fill_count;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the request being accepted
        logic execute;   // update queue state, issue the store access
        logic load;      // move the result into the output register
    } ctl_t;

endpackage

FILE: hw/rtl/mqrl_ram.sv
// mqrl_ram: generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mqrl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/mqrl_ctrl.sv
// mqrl_ctrl: request/response handshake control and the three-state sequencer
// that steps the datapath. Depends on mqrl_pkg.
module mqrl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output mqrl_pkg::ctl_t ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    assign out_free = !out_valid_reg || !rsp_stall;

    always_comb
    begin
        case (state_reg)
            S_IDLE:  req_stall = 1'b0;
            S_OUT:   req_stall = !out_free;
            default: req_stall = 1'b1;
        endcase
    end

    assign accept      = req_valid && !req_stall;
    assign ctl.capture = accept;
    assign ctl.execute = (state_reg == S_EXEC);
    assign ctl.load    = (state_reg == S_OUT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                // hold while the previous response still waits
                if (out_free)
                begin
                    state_next = accept ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !rsp_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

FILE: hw/rtl/mqrl_datapath.sv
// mqrl_datapath: per-queue pointers, ready marks, ready ring, message store
// and the response register. Depends on mqrl_pkg and mqrl_ram.
module mqrl_datapath #(
    parameter int NUM_QUEUES   = 16,
    parameter int QUEUE_DEPTH  = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  mqrl_pkg::ctl_t ctl,
    input  mqrl_pkg::req_t req,
    output mqrl_pkg::rsp_t rsp
);

    localparam int QW  = $clog2(NUM_QUEUES);
    localparam int DW  = $clog2(QUEUE_DEPTH);
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int RFW = $clog2(NUM_QUEUES + 1);
    // one spare bit so the queue count itself fits for the range compare
    localparam int IXW = ((QW > mqrl_pkg::QID_W) ? QW : mqrl_pkg::QID_W) + 1;
    localparam int SLW = FW + 1;
    localparam int RSW = RFW + 1;
    localparam int MD  = NUM_QUEUES * QUEUE_DEPTH;
    localparam int AW  = $clog2(MD);

    mqrl_pkg::req_t req_reg;

    logic [DW-1:0]  queue_head_reg [NUM_QUEUES];
    logic [FW-1:0]  queue_fill_reg [NUM_QUEUES];
    logic           ready_mark_reg [NUM_QUEUES];
    logic [QW-1:0]  ready_ring_reg [NUM_QUEUES];
    logic [QW-1:0]  ring_head_reg;
    logic [RFW-1:0] ring_fill_reg;

    // pending result between execute and load
    logic [mqrl_pkg::STATUS_W-1:0] res_status_reg;
    logic [mqrl_pkg::QID_W-1:0]    res_rq_reg;
    logic                          res_msg_reg;

    mqrl_pkg::rsp_t rsp_reg;

    logic [IXW-1:0] rd_ext;
    logic           rd_in_range;
    logic [QW-1:0]  rd_idx;
    logic [DW-1:0]  cur_head;
    logic [FW-1:0]  cur_fill;
    logic           cur_mark;
    logic [DW-1:0]  head_inc;
    logic [SLW-1:0] slot_sum;
    logic [DW-1:0]  slot;
    logic [QW-1:0]  ring_head_inc;
    logic [RSW-1:0] ring_sum;
    logic [QW-1:0]  ring_widx;
    logic [AW-1:0]  qbase;

    logic do_push;
    logic do_mark;
    logic do_ring_pop;
    logic do_pop;
    logic do_clear;
    logic [mqrl_pkg::STATUS_W-1:0] ex_status;
    logic [mqrl_pkg::QID_W-1:0]    ex_rq;

    logic                    ram_we;
    logic                    ram_re;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [PAYLOAD_BITS-1:0] ram_rdata;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            req_reg <= req;
        end
    end

    // one read port into the per-queue state: the request's queue while
    // executing, the result's queue while loading the response
    assign rd_ext      = ctl.load ? IXW'(res_rq_reg) : IXW'(req_reg.queue_id);
    assign rd_in_range = (rd_ext < IXW'(NUM_QUEUES));
    assign rd_idx      = rd_ext[QW-1:0];
    assign cur_head    = queue_head_reg[rd_idx];
    assign cur_fill    = queue_fill_reg[rd_idx];
    assign cur_mark    = ready_mark_reg[rd_idx];

    assign head_inc = (cur_head == DW'(QUEUE_DEPTH - 1)) ? '0 : cur_head + 1'b1;
    assign slot_sum = SLW'(cur_head) + SLW'(cur_fill);
    assign slot     = (slot_sum >= SLW'(QUEUE_DEPTH)) ?
                      DW'(slot_sum - SLW'(QUEUE_DEPTH)) : DW'(slot_sum);
    assign qbase    = AW'(AW'(rd_idx) * AW'(QUEUE_DEPTH));

    assign ring_head_inc = (ring_head_reg == QW'(NUM_QUEUES - 1)) ?
                           '0 : ring_head_reg + 1'b1;
    assign ring_sum      = RSW'(ring_head_reg) + RSW'(ring_fill_reg);
    assign ring_widx     = (ring_sum >= RSW'(NUM_QUEUES)) ?
                           QW'(ring_sum - RSW'(NUM_QUEUES)) : QW'(ring_sum);

    always_comb
    begin
        do_push     = 1'b0;
        do_mark     = 1'b0;
        do_ring_pop = 1'b0;
        do_pop      = 1'b0;
        do_clear    = 1'b0;
        ex_status   = mqrl_pkg::ST_OK;
        ex_rq       = req_reg.queue_id;
        case (req_reg.cmd)
            mqrl_pkg::CMD_PUSH:
            begin
                if (!rd_in_range || cur_fill >= FW'(QUEUE_DEPTH))
                begin
                    ex_status = mqrl_pkg::ST_FULL;
                end
                else
                begin
                    do_push = 1'b1;
                    do_mark = !cur_mark && (ring_fill_reg < RFW'(NUM_QUEUES));
                end
            end
            mqrl_pkg::CMD_RING_POP:
            begin
                if (ring_fill_reg == '0)
                begin
                    ex_status = mqrl_pkg::ST_EMPTY;
                end
                else
                begin
                    do_ring_pop = 1'b1;
                    ex_rq       = mqrl_pkg::QID_W'(ready_ring_reg[ring_head_reg]);
                end
            end
            mqrl_pkg::CMD_POP:
            begin
                if (!rd_in_range)
                begin
                    ex_status = mqrl_pkg::ST_EMPTY;
                end
                else if (cur_fill == '0)
                begin
                    do_clear  = 1'b1;
                    ex_status = mqrl_pkg::ST_EMPTY;
                end
                else
                begin
                    do_pop = 1'b1;
                end
            end
            default:
            begin
                ex_status = mqrl_pkg::ST_OK;
            end
        endcase
    end

    assign ram_we    = ctl.execute && do_push;
    assign ram_re    = ctl.execute && do_pop;
    assign ram_waddr = qbase + AW'(slot);
    assign ram_raddr = qbase + AW'(cur_head);

    mqrl_ram #(
        .WIDTH (PAYLOAD_BITS),
        .DEPTH (MD)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (PAYLOAD_BITS'(req_reg.payload)),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                queue_head_reg[i] <= '0;
                queue_fill_reg[i] <= '0;
                ready_mark_reg[i] <= 1'b0;
            end
            ring_head_reg <= '0;
            ring_fill_reg <= '0;
        end
        else if (ctl.execute)
        begin
            if (do_push)
            begin
                queue_fill_reg[rd_idx] <= cur_fill + 1'b1;
            end
            if (do_mark)
            begin
                ready_mark_reg[rd_idx] <= 1'b1;
                ring_fill_reg          <= ring_fill_reg + 1'b1;
            end
            if (do_ring_pop)
            begin
                ring_head_reg <= ring_head_inc;
                ring_fill_reg <= ring_fill_reg - 1'b1;
            end
            if (do_pop)
            begin
                queue_head_reg[rd_idx] <= head_inc;
                queue_fill_reg[rd_idx] <= cur_fill - 1'b1;
            end
            if (do_clear)
            begin
                ready_mark_reg[rd_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.execute && do_mark)
        begin
            ready_ring_reg[ring_widx] <= rd_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.execute)
        begin
            res_status_reg <= ex_status;
            res_rq_reg     <= ex_rq;
            res_msg_reg    <= do_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rsp_reg.status      <= res_status_reg;
            rsp_reg.ready_queue <= res_rq_reg;
            rsp_reg.message     <= res_msg_reg ?
                                   mqrl_pkg::PAYLOAD_W'(ram_rdata) : '0;
            rsp_reg.fill_count  <= rd_in_range ?
                                   mqrl_pkg::FILL_W'(cur_fill) : '0;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: hw/rtl/multi_queue_ready_list_core.sv
// Per-queue message FIFOs with a global ready ring of queue numbers.
//
// Channels: req (cmd, queue_id, payload) in, rsp (status, ready_queue,
// message, fill_count) out, each with valid and stall; a transfer happens
// on a rising edge with valid high and stall low. Every request gives
// exactly one response, in request order.
// cmd push appends payload to a queue and, if the queue is not marked ready
// and the ring has room, puts it on the ready ring; ring pop returns the oldest
// ready queue number; payload pop returns the oldest word of a queue, and an
// empty pop takes the queue off the ready set. Full pushes are dropped (status 2).
// Timing: a request executes in the cycle after it is accepted, and its
// response is registered into rsp once the output register is free. A new
// request is taken while a response loads, but never while one executes,
// due to the read-modify-write of the per-queue pointers and the registered
// read of the message store. With rsp stalled and a response waiting, the
// core finishes the request in flight, then holds it and stalls req.
// Reset: all queues empty, no queue marked, ring empty, no response valid.
module multi_queue_ready_list_core #(
    parameter int NUM_QUEUES   = 16,
    parameter int QUEUE_DEPTH  = 16,
    parameter int PAYLOAD_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  mqrl_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output mqrl_pkg::rsp_t rsp
);

    mqrl_pkg::ctl_t ctl;

    mqrl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctl       (ctl)
    );

    mqrl_datapath #(
        .NUM_QUEUES   (NUM_QUEUES),
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .req   (req),
        .rsp   (rsp)
    );

    // no new request while one is executing
    a_no_accept_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.execute |-> !ctl.capture)
        else $error("request accepted during execute");

    // an accepted request executes in the next cycle
    a_capture_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.capture |=> ctl.execute)
        else $error("accepted request did not execute");

    // after execute, the result loads unless a stalled response blocks it
    a_exec_then_load: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.execute |=> (ctl.load || (rsp_valid && rsp_stall)))
        else $error("result neither loaded nor blocked");

    // a load always presents a response in the next cycle
    a_load_then_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load |=> rsp_valid)
        else $error("loaded response not valid");

endmodule
